// ===== hw/rtl/lzwd_pkg.sv =====
// Shared types and constants for the LZ window decompressor.
// Depends on nothing; imported by the parser, copy engine and top level.
package lzwd_pkg;

  // History window and queue sizing
  localparam int LZWD_HISTORY_DEPTH = 4096;
  localparam int LZWD_CMD_DEPTH     = 4;
  localparam int LZWD_RES_DEPTH     = 4;

  // Field widths
  localparam int DIST_W  = 12;
  localparam int LCODE_W = 4;
  localparam int RUN_W   = LCODE_W + 1;
  localparam int TOTAL_W = 32;

  // Stream constants
  localparam logic [7:0]   TOKEN_END  = 8'h00;
  localparam logic [3:0]   FLAG_COUNT = 4'd8;
  localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;

  // Work items passed from the parser to the copy engine
  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_END
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [7:0]           lit;
    logic [DIST_W-1:0]    distance;
    logic [LCODE_W-1:0]   len_code;
  } lzwd_cmd_t;

  // One result beat
  typedef struct packed {
    logic [7:0]          data_byte;
    logic                byte_valid;
    logic                run_last;
    logic                stream_end;
    logic [TOTAL_W-1:0]  total_length;
  } lzwd_res_t;

endpackage

// ===== hw/rtl/lzwd_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
// Standalone; used for the command queue and the result queue.
module lzwd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/lzwd_parser.sv =====
// Front end: walks tag flags and turns compressed bytes into commands.
// Depends on lzwd_pkg for the command type and stream constants.
module lzwd_parser
  import lzwd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [7:0] in_byte,
  output logic      cmd_valid,
  output lzwd_cmd_t cmd
);

  typedef enum logic [1:0] {
    PH_TAG,
    PH_SYM,
    PH_DIST
  } phase_t;

  phase_t       phase, phase_next;
  logic [7:0]   flag_bits, flag_bits_next;
  logic [3:0]   flags_left, flags_left_next;
  logic [7:0]   pending, pending_next;
  logic [3:0]   left_dec;
  logic [7:0]   flags_shift;

  assign left_dec    = (flags_left != '0) ? flags_left - 1'b1 : flags_left;
  assign flags_shift = {flag_bits[6:0], 1'b0};

  // Classify the incoming beat
  always_comb begin
    cmd_valid       = 1'b0;
    cmd.kind        = CMD_LIT;
    cmd.lit         = in_byte;
    cmd.distance    = {pending[7:4], in_byte};
    cmd.len_code    = pending[3:0];
    phase_next      = phase;
    flag_bits_next  = flag_bits;
    flags_left_next = flags_left;
    pending_next    = pending;
    if (accept) begin
      unique case (phase)
        PH_SYM: begin
          if (!flag_bits[7]) begin
            cmd_valid       = 1'b1;
            cmd.kind        = CMD_LIT;
            flag_bits_next  = flags_shift;
            flags_left_next = left_dec;
            phase_next      = (left_dec == '0) ? PH_TAG : PH_SYM;
          end else if (in_byte == TOKEN_END) begin
            cmd_valid       = 1'b1;
            cmd.kind        = CMD_END;
            flag_bits_next  = '0;
            flags_left_next = '0;
            pending_next    = '0;
            phase_next      = PH_TAG;
          end else begin
            pending_next = in_byte;
            phase_next   = PH_DIST;
          end
        end
        PH_DIST: begin
          cmd_valid       = 1'b1;
          cmd.kind        = CMD_COPY;
          pending_next    = '0;
          flag_bits_next  = flags_shift;
          flags_left_next = left_dec;
          phase_next      = (left_dec == '0) ? PH_TAG : PH_SYM;
        end
        default: begin
          // tag byte, also the unused phase code
          flag_bits_next  = in_byte;
          flags_left_next = FLAG_COUNT;
          phase_next      = PH_SYM;
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TAG;
      flag_bits  <= '0;
      flags_left <= '0;
      pending    <= '0;
    end else begin
      phase      <= phase_next;
      flag_bits  <= flag_bits_next;
      flags_left <= flags_left_next;
      pending    <= pending_next;
    end
  end

endmodule

// ===== hw/rtl/lzwd_copy_engine.sv =====
// Back end: expands commands into output beats through the history window.
// Depends on lzwd_pkg; holds the history memory and the output counter.
module lzwd_copy_engine
  import lzwd_pkg::*;
#(
  parameter int HISTORY_DEPTH = LZWD_HISTORY_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_empty,
  input  lzwd_cmd_t cmd,
  output logic      cmd_pop,
  input  logic      res_full,
  output logic      res_push,
  output lzwd_res_t res
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic [7:0]         mem [HISTORY_DEPTH];

  // issue stage
  logic [AW-1:0]      ipt;
  logic [RUN_W-1:0]   run_idx;
  logic               s1_go;
  logic               s1_last;
  logic [AW-1:0]      raddr;

  // write stage
  logic               s2_valid;
  cmd_kind_t          s2_kind;
  logic [7:0]         s2_lit;
  logic               s2_last;
  logic               byp_hit;
  logic [7:0]         byp_data;
  logic               rd_ok;
  logic [7:0]         mem_q;
  logic               s2_go;
  logic               wr_en;
  logic [7:0]         wr_byte;

  // window fill tracking
  logic [AW-1:0]      wpw;
  logic               wrapped;
  logic [TOTAL_W-1:0] out_count;

  assign s2_go   = s2_valid && !res_full;
  assign s1_go   = !cmd_empty && (!s2_valid || s2_go) && !(s2_valid && s2_kind == CMD_END);
  assign s1_last = (cmd.kind != CMD_COPY) || (run_idx == {1'b0, cmd.len_code} + 1'b1);
  assign cmd_pop = s1_go && s1_last;
  assign raddr   = ipt - AW'(cmd.distance);

  // Byte leaving the write stage; unwritten entries read as zero
  always_comb begin
    if (s2_kind == CMD_LIT) begin
      wr_byte = s2_lit;
    end else if (byp_hit) begin
      wr_byte = byp_data;
    end else if (rd_ok) begin
      wr_byte = mem_q;
    end else begin
      wr_byte = '0;
    end
  end

  assign wr_en    = s2_go && (s2_kind != CMD_END);
  assign res_push = s2_go;

  always_comb begin
    res.data_byte    = (s2_kind == CMD_END) ? 8'h00 : wr_byte;
    res.byte_valid   = (s2_kind != CMD_END);
    res.run_last     = s2_last;
    res.stream_end   = (s2_kind == CMD_END);
    res.total_length = (s2_kind == CMD_END) ? out_count : '0;
  end

  // History memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wpw] <= wr_byte;
    end
    if (s1_go) begin
      mem_q <= mem[raddr];
    end
  end

  // Write-stage payload, with bypass of the byte written on the same edge
  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_kind  <= cmd.kind;
      s2_lit   <= cmd.lit;
      s2_last  <= s1_last;
      byp_hit  <= wr_en && (wpw == raddr);
      byp_data <= wr_byte;
      rd_ok    <= wrapped || (raddr < wpw);
    end
  end

  // Control: issue pointer, run index, stage valid, window fill
  always_ff @(posedge clk) begin
    if (rst) begin
      ipt       <= '0;
      run_idx   <= '0;
      s2_valid  <= 1'b0;
      wpw       <= '0;
      wrapped   <= 1'b0;
      out_count <= '0;
    end else begin
      if (s1_go) begin
        run_idx <= s1_last ? '0 : run_idx + 1'b1;
        ipt     <= (cmd.kind == CMD_END) ? '0 : ipt + 1'b1;
      end
      if (s1_go) begin
        s2_valid <= 1'b1;
      end else if (s2_go) begin
        s2_valid <= 1'b0;
      end
      if (s2_go) begin
        if (s2_kind == CMD_END) begin
          wpw       <= '0;
          wrapped   <= 1'b0;
          out_count <= '0;
        end else begin
          wpw     <= wpw + 1'b1;
          wrapped <= wrapped || (wpw == '1);
          if (out_count != COUNT_MAX) begin
            out_count <= out_count + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/lz_window_decompressor_unit.sv =====
// LZSS decompressor with a 4096-byte window, one compressed byte per input beat.
// A compressed byte is taken whenever the command queue has room. The copy engine
// produces one output byte per cycle while the result queue has room, bounded by the
// single read port of the history memory; a literal yields one byte and a match of
// length L (2..17) yields L bytes. After an end token the engine issues nothing until
// that token leaves the write stage, where the window is reset; no clearing pass is
// needed, since a fill pointer marks which entries belong to the current stream.
// Results sit in a short output queue, so input flows while they wait, until queues fill.
// Depends on lzwd_pkg, lzwd_fifo, lzwd_parser and lzwd_copy_engine.
module lz_window_decompressor_unit
  import lzwd_pkg::*;
#(
  parameter int HISTORY_DEPTH = LZWD_HISTORY_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [7:0]         in_byte,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         data_byte,
  output logic               byte_valid,
  output logic               run_last,
  output logic               stream_end,
  output logic [TOTAL_W-1:0] total_length
);

  localparam int CMD_W = $bits(lzwd_cmd_t);
  localparam int RES_W = $bits(lzwd_res_t);

  logic             accept;
  logic             cmd_valid;
  lzwd_cmd_t        cmd_in;
  logic [CMD_W-1:0] cmd_bits;
  lzwd_cmd_t        cmd_head;
  logic             cmd_empty;
  logic             cmd_pop;
  logic             res_full;
  logic             res_push;
  lzwd_res_t        res_in;
  logic [RES_W-1:0] res_bits;
  lzwd_res_t        res_head;

  assign accept = push && !full;

  // Front end
  lzwd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in)
  );

  // Command queue between front and back
  lzwd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (LZWD_CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_valid),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd_head = lzwd_cmd_t'(cmd_bits);

  // Back end
  lzwd_copy_engine #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue
  lzwd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (LZWD_RES_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  assign res_head     = lzwd_res_t'(res_bits);
  assign data_byte    = res_head.data_byte;
  assign byte_valid   = res_head.byte_valid;
  assign run_last     = res_head.run_last;
  assign stream_end   = res_head.stream_end;
  assign total_length = res_head.total_length;

endmodule

// ===== tb/lz_window_decompressor_unit_test.sv =====
// Self-checking testbench for lz_window_decompressor_unit: directed and random LZSS
// streams with a bit-accurate window predictor; depends on lzwd_pkg and the unit RTL.
module lz_window_decompressor_unit_test;
  import lzwd_pkg::*;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_ITEM,
    PH_DIST
  } parse_phase_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic [7:0]         in_byte = 8'h00;
  logic               full;
  logic               empty;
  logic               pop = 1'b0;
  logic [7:0]         data_byte;
  logic               byte_valid;
  logic               run_last;
  logic               stream_end;
  logic [TOTAL_W-1:0] total_length;

  // Predictor state
  logic [7:0]         window_mem [0:LZWD_HISTORY_DEPTH-1];
  logic [DIST_W-1:0]  write_ptr;
  logic [7:0]         flag_bits;
  logic [3:0]         flags_left;
  parse_phase_t       parse_phase;
  logic [7:0]         pending_token;
  logic [TOTAL_W-1:0] output_count;
  lzwd_res_t          decoded_beats_q [$];

  int sender_idle_pct = 36;
  int receiver_idle_pct = 67;
  int stall_requests = 0;
  int items_sent = 0;
  int mismatch_count = 0;

  lz_window_decompressor_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .in_byte      (in_byte),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .data_byte    (data_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .stream_end   (stream_end),
    .total_length (total_length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------- predictor ----------------

  // Empty window, counters and parser, as after reset or an end token
  task automatic clear_stream();
    for (int i = 0; i < LZWD_HISTORY_DEPTH; i++) window_mem[i] = 8'h00;
    write_ptr     = '0;
    flag_bits     = '0;
    flags_left    = '0;
    parse_phase   = PH_TAG;
    pending_token = '0;
    output_count  = '0;
  endtask

  task automatic put_window_byte(input logic [7:0] v);
    window_mem[write_ptr] = v;
    write_ptr = write_ptr + 1'b1;
    if (output_count != COUNT_MAX) output_count = output_count + 1'b1;
  endtask

  task automatic take_flag();
    flag_bits = flag_bits << 1;
    if (flags_left > 0) flags_left = flags_left - 1'b1;
    parse_phase = (flags_left == 0) ? PH_TAG : PH_ITEM;
  endtask

  // Expected output beats for one accepted compressed byte
  task automatic decode_compressed_byte(input logic [7:0] b);
    lzwd_res_t         beat;
    logic [DIST_W-1:0] distance;
    logic [DIST_W-1:0] rd_ptr;
    int                run_len;
    beat = '0;
    case (parse_phase)
      PH_ITEM: begin
        if (!flag_bits[7]) begin
          put_window_byte(b);
          take_flag();
          beat.data_byte  = b;
          beat.byte_valid = 1'b1;
          beat.run_last   = 1'b1;
          decoded_beats_q.push_back(beat);
        end else if (b == TOKEN_END) begin
          beat.run_last     = 1'b1;
          beat.stream_end   = 1'b1;
          beat.total_length = output_count;
          decoded_beats_q.push_back(beat);
          clear_stream();
        end else begin
          pending_token = b;
          parse_phase   = PH_DIST;
        end
      end
      PH_DIST: begin
        distance = {pending_token[7:4], b};
        run_len  = pending_token[3:0] + 2;
        // byte-by-byte so overlapping copies see freshly written bytes
        for (int i = 0; i < run_len; i++) begin
          rd_ptr = write_ptr - distance;
          beat = '0;
          beat.data_byte  = window_mem[rd_ptr];
          beat.byte_valid = 1'b1;
          beat.run_last   = (i == run_len - 1);
          put_window_byte(beat.data_byte);
          decoded_beats_q.push_back(beat);
        end
        pending_token = '0;
        take_flag();
      end
      default: begin
        // tag byte, also the unused phase value
        flag_bits   = b;
        flags_left  = FLAG_COUNT;
        parse_phase = PH_ITEM;
      end
    endcase
  endtask

  // ---------------- stimulus ----------------

  // Offer one byte, idling at random first; returns at the accepting edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (full);
    decode_compressed_byte(b);
    items_sent++;
  endtask

  // One well-formed stream: tags with random literals and matches, closed by an end token
  task automatic send_random_stream();
    logic [7:0]        tag;
    logic [7:0]        token;
    logic [3:0]        len_code;
    logic [DIST_W-1:0] distance;
    int                tag_count;
    bit                ended;
    ended = 1'b0;
    tag_count = $urandom_range(1, 4);
    for (int t = 0; t < tag_count && !ended; t++) begin
      tag = 8'($urandom_range(255));
      send_byte(tag);
      for (int k = 7; k >= 0 && !ended; k--) begin
        if (!tag[k]) begin
          send_byte(8'($urandom_range(255)));
        end else if ($urandom_range(15) == 0) begin
          send_byte(TOKEN_END);
          ended = 1'b1;
        end else begin
          // mostly short distances so copies pick up real data
          distance = ($urandom_range(3) == 0) ? DIST_W'($urandom_range(4095))
                                               : DIST_W'($urandom_range(1, 24));
          len_code = 4'($urandom_range(15));
          token    = {distance[11:8], len_code};
          if (token == TOKEN_END) token = 8'h01;
          send_byte(token);
          send_byte(distance[7:0]);
        end
      end
    end
    if (!ended) begin
      send_byte(8'h80 | 8'($urandom_range(127)));
      send_byte(TOKEN_END);
    end
  endtask

  // Random streams mixed with short bursts of noise bytes
  task automatic send_stream_mix(input int item_count);
    int start;
    start = items_sent;
    while (items_sent - start < item_count) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(255)));
      end else begin
        send_random_stream();
      end
    end
  endtask

  // ---------------- tests ----------------

  // Literal extremes, longest overlapping copy, distance zero, farthest distance,
  // end token, window clearing and an empty stream
  task automatic test_directed_streams();
    logic [7:0] seq [$];
    seq = {8'h00, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
           8'hF0, 8'h0F, 8'h01, 8'h01, 8'h00, 8'hF0, 8'hFF, TOKEN_END,
           8'h60, 8'h12, 8'h02, 8'h05, TOKEN_END,
           8'h80, TOKEN_END};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Receiver holds off while the sender keeps going, so the unit backs up
  task automatic test_output_backpressure();
    int start;
    stall_requests <= stall_requests + 1;
    start = items_sent;
    while (items_sent - start < 25) send_random_stream();
  endtask

  task automatic test_random_streams(input int tx_idle, input int rx_idle, input int count);
    sender_idle_pct = tx_idle;
    receiver_idle_pct <= rx_idle;
    send_stream_mix(count);
  endtask

  // ---------------- result checking ----------------

  task automatic compare_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  // Checks each popped beat and drives pop, with a counted long hold-off on request
  initial begin
    lzwd_res_t want;
    int        stall_seen;
    int        stall_left;
    stall_seen = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (decoded_beats_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual data_byte %0h", $time,
                   data_byte);
          mismatch_count++;
        end else begin
          want = decoded_beats_q.pop_front();
          compare_field("data_byte", want.data_byte, data_byte);
          compare_field("byte_valid", want.byte_valid, byte_valid);
          compare_field("run_last", want.run_last, run_last);
          compare_field("stream_end", want.stream_end, stream_end);
          compare_field("total_length", want.total_length, total_length);
        end
      end
      if (stall_requests != stall_seen) begin
        stall_seen = stall_requests;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    clear_stream();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_streams();
    test_output_backpressure();
    test_random_streams(36, 67, 35);
    test_random_streams(67, 36, 35);
    test_random_streams(0, 0, 35);
    push <= 1'b0;

    while (decoded_beats_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
